// ===== design/rlw_pkg.sv =====
`timescale 1ns / 1ps

package rlw_pkg;

    // field widths
    localparam int CPU_W   = 6;
    localparam int TIME_W  = 64;
    localparam int PID_W   = 23;
    localparam int FLAGS_W = 64;
    localparam int CUR_W   = 32;
    localparam int TICK_W  = 32;
    localparam int FBIT_W  = 6;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 1;

    // cpu field can address at most this many entries
    localparam int CPU_SPAN = 1 << CPU_W;

    // operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SWITCH = 1'b1;

    // reporter codes
    localparam logic REPORTER_TICK   = 1'b0;
    localparam logic REPORTER_SWITCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BIT  = 1'b1;

    // reset value of the flag bit position
    localparam logic [FBIT_W-1:0] FLAG_BIT_RESET = 6'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic result;
        logic out_free;
    } sts_t;

endpackage

// ===== design/resched_latency_watchdog_unit.sv =====
`timescale 1ns / 1ps

// Rescheduling-latency watchdog with one table entry per CPU (NUM_CPUS entries, at most the
// 64 that the cpu field can address). Each item is accepted in the idle state, which reads
// the CPU's entry from the table memories, whose read port is registered, and is then
// evaluated in the execute state, which writes the entry back. The evaluate state is held
// for as long as a new report finds the output register still occupied. Items are taken
// one at a time, so a new item is accepted only after the last one is written back; a
// waiting report holds up further items only when the item being evaluated also reports.
// Entry presence lives in flip-flops cleared by reset, so no clearing pass follows reset.
// Configuration writes take effect at once and belong between items.
module resched_latency_watchdog_unit #(
    parameter int NUM_CPUS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [rlw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlw_pkg::CFG_W-1:0]       cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [rlw_pkg::CPU_W-1:0]       cpu,
    input  logic [rlw_pkg::TIME_W-1:0]      now_ns,
    input  logic [rlw_pkg::PID_W-1:0]       task_pid,
    input  logic [rlw_pkg::FLAGS_W-1:0]     thread_flags,
    input  logic [rlw_pkg::CUR_W-1:0]       current_pid,
    // report items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            reporter,
    output logic [rlw_pkg::CPU_W-1:0]       report_cpu,
    output logic [rlw_pkg::TIME_W-1:0]      stamp_ns,
    output logic [rlw_pkg::TIME_W-1:0]      delay_ns,
    output logic [rlw_pkg::TIME_W-1:0]      enter_ns,
    output logic [rlw_pkg::TIME_W-1:0]      exit_ns,
    output logic [rlw_pkg::CUR_W-1:0]       report_pid
);

    rlw_pkg::cmd_t cmd;
    rlw_pkg::sts_t sts;

    // sequencer
    rlw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and report datapath
    rlw_datapath #(
        .NUM_CPUS (NUM_CPUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .cpu          (cpu),
        .now_ns       (now_ns),
        .task_pid     (task_pid),
        .thread_flags (thread_flags),
        .current_pid  (current_pid),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reporter     (reporter),
        .report_cpu   (report_cpu),
        .stamp_ns     (stamp_ns),
        .delay_ns     (delay_ns),
        .enter_ns     (enter_ns),
        .exit_ns      (exit_ns),
        .report_pid   (report_pid)
    );

    // accept and write-back never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.accept && cmd.commit))
        else $error("accept and commit in the same cycle");

    // the block is busy in the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n) cmd.accept |=> !in_ready)
        else $error("input ready right after an accept");

    // a report never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && sts.result) |-> (!out_valid || out_ready))
        else $error("report committed over a pending report");

    // a report appears only after a write-back
    assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(cmd.commit))
        else $error("report without a commit");

endmodule

// ===== design/rlw_ctrl.sv =====
`timescale 1ns / 1ps

module rlw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rlw_pkg::sts_t sts,
    output rlw_pkg::cmd_t cmd
);

    rlw_pkg::state_t state_reg;
    rlw_pkg::state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rlw_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = rlw_pkg::ST_EXEC;
                end
            end
            rlw_pkg::ST_EXEC:
            begin
                // hold while a new result cannot enter the output register
                if (!sts.result || sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = rlw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlw_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/rlw_datapath.sv =====
`timescale 1ns / 1ps

module rlw_datapath #(
    parameter int NUM_CPUS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rlw_pkg::cmd_t                   cmd,
    output rlw_pkg::sts_t                   sts,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [rlw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlw_pkg::CFG_W-1:0]       cfg_data,
    // input item
    input  logic                            operation,
    input  logic [rlw_pkg::CPU_W-1:0]       cpu,
    input  logic [rlw_pkg::TIME_W-1:0]      now_ns,
    input  logic [rlw_pkg::PID_W-1:0]       task_pid,
    input  logic [rlw_pkg::FLAGS_W-1:0]     thread_flags,
    input  logic [rlw_pkg::CUR_W-1:0]       current_pid,
    // result item
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            reporter,
    output logic [rlw_pkg::CPU_W-1:0]       report_cpu,
    output logic [rlw_pkg::TIME_W-1:0]      stamp_ns,
    output logic [rlw_pkg::TIME_W-1:0]      delay_ns,
    output logic [rlw_pkg::TIME_W-1:0]      enter_ns,
    output logic [rlw_pkg::TIME_W-1:0]      exit_ns,
    output logic [rlw_pkg::CUR_W-1:0]       report_pid
);

    localparam int TABLE_DEPTH = (NUM_CPUS < rlw_pkg::CPU_SPAN) ? NUM_CPUS : rlw_pkg::CPU_SPAN;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [rlw_pkg::TIME_W-1:0] threshold_reg;
    logic [rlw_pkg::FBIT_W-1:0] flag_bit_reg;

    // captured item
    logic                        op_reg;
    logic [rlw_pkg::CPU_W-1:0]   cpu_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        range_reg;
    logic                        qual_reg;
    logic [rlw_pkg::TIME_W-1:0]  now_reg;
    logic [rlw_pkg::CUR_W-1:0]   cur_reg;

    // per-cpu table
    logic [TABLE_DEPTH-1:0]      present_reg;
    logic [rlw_pkg::TIME_W-1:0]  first_mem [TABLE_DEPTH];
    logic [rlw_pkg::TICK_W-1:0]  tick_mem  [TABLE_DEPTH];
    logic [rlw_pkg::TIME_W-1:0]  last_mem  [TABLE_DEPTH];
    logic [rlw_pkg::TIME_W-1:0]  first_rd_reg;
    logic [rlw_pkg::TICK_W-1:0]  tick_rd_reg;
    logic [rlw_pkg::TIME_W-1:0]  last_rd_reg;

    // evaluation
    logic                        present_q;
    logic [rlw_pkg::TIME_W-1:0]  since_first;
    logic [rlw_pkg::TIME_W-1:0]  since_last;
    logic                        present_set;
    logic                        first_we;
    logic [rlw_pkg::TIME_W-1:0]  first_wdata;
    logic                        tick_we;
    logic [rlw_pkg::TICK_W-1:0]  tick_wdata;
    logic                        last_we;
    logic                        result;
    logic                        is_switch;
    logic [IDX_W-1:0]            in_idx;
    logic                        in_range;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_load;
    logic                        reporter_reg;
    logic [rlw_pkg::CPU_W-1:0]   report_cpu_reg;
    logic [rlw_pkg::TIME_W-1:0]  stamp_reg;
    logic [rlw_pkg::TIME_W-1:0]  delay_reg;
    logic [rlw_pkg::TIME_W-1:0]  enter_reg;
    logic [rlw_pkg::TIME_W-1:0]  exit_reg;
    logic [rlw_pkg::CUR_W-1:0]   report_pid_reg;

    assign in_idx   = cpu[IDX_W-1:0];
    assign in_range = (int'(cpu) < NUM_CPUS);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            flag_bit_reg  <= rlw_pkg::FLAG_BIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlw_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                rlw_pkg::REG_FLAG_BIT:  flag_bit_reg  <= cfg_data[rlw_pkg::FBIT_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture, tick qualification done on the way in
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= operation;
            cpu_reg   <= cpu;
            idx_reg   <= in_idx;
            range_reg <= in_range;
            qual_reg  <= (task_pid != '0) && thread_flags[flag_bit_reg];
            now_reg   <= now_ns;
            cur_reg   <= current_pid;
        end
    end

    // table memories, read on accept, written on commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            first_rd_reg <= first_mem[in_idx];
        end
        if (cmd.commit && first_we)
        begin
            first_mem[idx_reg] <= first_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tick_rd_reg <= tick_mem[in_idx];
        end
        if (cmd.commit && tick_we)
        begin
            tick_mem[idx_reg] <= tick_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            last_rd_reg <= last_mem[in_idx];
        end
        if (cmd.commit && last_we)
        begin
            last_mem[idx_reg] <= now_reg;
        end
    end

    // entry present bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (cmd.commit && present_set)
        begin
            present_reg[idx_reg] <= 1'b1;
        end
    end

    // evaluate the captured item against its table entry
    always_comb
    begin
        present_q   = present_reg[idx_reg];
        since_first = now_reg - first_rd_reg;
        since_last  = now_reg - last_rd_reg;
        is_switch   = (op_reg == rlw_pkg::OP_SWITCH);
        present_set = 1'b0;
        first_we    = 1'b0;
        first_wdata = now_reg;
        tick_we     = 1'b0;
        tick_wdata  = '0;
        last_we     = 1'b0;
        result      = 1'b0;
        if (range_reg)
        begin
            if (!is_switch)
            begin
                if (qual_reg)
                begin
                    if (!present_q || (first_rd_reg == '0))
                    begin
                        // create or re-arm the entry
                        present_set = 1'b1;
                        first_we    = 1'b1;
                        tick_we     = 1'b1;
                        last_we     = 1'b1;
                    end
                    else
                    begin
                        tick_we    = 1'b1;
                        tick_wdata = tick_rd_reg + rlw_pkg::TICK_W'(1);
                        if (since_last > threshold_reg)
                        begin
                            last_we = 1'b1;
                            result  = 1'b1;
                        end
                    end
                end
            end
            else if (present_q)
            begin
                // a switch always clears the first-seen time
                first_we    = 1'b1;
                first_wdata = '0;
                if ((threshold_reg != '0) && (first_rd_reg != '0)
                    && (since_first > threshold_reg))
                begin
                    last_we = 1'b1;
                    result  = 1'b1;
                end
            end
        end
    end

    assign sts.result   = result;
    assign sts.out_free = !out_valid_reg || out_ready;

    // output handshake
    assign out_load = cmd.commit && result;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            reporter_reg   <= is_switch ? rlw_pkg::REPORTER_SWITCH : rlw_pkg::REPORTER_TICK;
            report_cpu_reg <= cpu_reg;
            stamp_reg      <= is_switch ? now_reg : first_rd_reg;
            delay_reg      <= since_first;
            enter_reg      <= is_switch ? first_rd_reg : '0;
            exit_reg       <= is_switch ? now_reg : '0;
            report_pid_reg <= cur_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reporter   = reporter_reg;
    assign report_cpu = report_cpu_reg;
    assign stamp_ns   = stamp_reg;
    assign delay_ns   = delay_reg;
    assign enter_ns   = enter_reg;
    assign exit_ns    = exit_reg;
    assign report_pid = report_pid_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rlw_pkg::*;

    localparam int TB_CPUS = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN = 40;
    localparam logic [PID_W-1:0] PID_TOP = 23'd4194304;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    typedef struct packed {
        logic               op;
        logic [CPU_W-1:0]   cpu;
        logic [TIME_W-1:0]  now;
        logic [PID_W-1:0]   pid;
        logic [FLAGS_W-1:0] flags;
        logic [CUR_W-1:0]   cur;
    } sched_event_t;

    typedef struct packed {
        logic              who;
        logic [CPU_W-1:0]  cpu;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] enter;
        logic [TIME_W-1:0] leave;
        logic [CUR_W-1:0]  pid;
    } latency_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic operation;
    logic [CPU_W-1:0] cpu;
    logic [TIME_W-1:0] now_ns;
    logic [PID_W-1:0] task_pid;
    logic [FLAGS_W-1:0] thread_flags;
    logic [CUR_W-1:0] current_pid;
    logic out_valid;
    logic out_ready;
    logic reporter;
    logic [CPU_W-1:0] report_cpu;
    logic [TIME_W-1:0] stamp_ns;
    logic [TIME_W-1:0] delay_ns;
    logic [TIME_W-1:0] enter_ns;
    logic [TIME_W-1:0] exit_ns;
    logic [CUR_W-1:0] report_pid;

    // watchdog copy of the per-cpu table and its settings
    logic              tbl_present [TB_CPUS];
    logic [TIME_W-1:0] tbl_first_seen [TB_CPUS];
    logic [TICK_W-1:0] tbl_ticks [TB_CPUS];
    logic [TIME_W-1:0] tbl_last_report [TB_CPUS];
    logic [TIME_W-1:0] cur_threshold;
    logic [FBIT_W-1:0] cur_flag_pos;

    latency_report_t expected_reports [$];
    logic [TIME_W-1:0] cpu_clock [TB_CPUS];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_off_req = 1'b0;

    resched_latency_watchdog_unit #(
        .NUM_CPUS(TB_CPUS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .cpu(cpu),
        .now_ns(now_ns),
        .task_pid(task_pid),
        .thread_flags(thread_flags),
        .current_pid(current_pid),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .reporter(reporter),
        .report_cpu(report_cpu),
        .stamp_ns(stamp_ns),
        .delay_ns(delay_ns),
        .enter_ns(enter_ns),
        .exit_ns(exit_ns),
        .report_pid(report_pid)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sched_event_t ev(logic op, logic [CPU_W-1:0] c, logic [TIME_W-1:0] t,
                                        logic [PID_W-1:0] p, logic [FLAGS_W-1:0] f,
                                        logic [CUR_W-1:0] cu);
        sched_event_t e;
        e.op = op;
        e.cpu = c;
        e.now = t;
        e.pid = p;
        e.flags = f;
        e.cur = cu;
        return e;
    endfunction

    // apply one item to the table copy; returns 1 when a report is due
    function automatic bit predict_report(input sched_event_t e, output latency_report_t r);
        logic [TIME_W-1:0] first;
        logic [TIME_W-1:0] since;
        r = '0;
        if (e.cpu >= TB_CPUS)
            return 1'b0;
        if (e.op == OP_TICK)
        begin
            if (e.pid == '0 || !e.flags[cur_flag_pos])
                return 1'b0;
            first = tbl_first_seen[e.cpu];
            // new entry, or an armed one whose first-seen time is zero
            if (!tbl_present[e.cpu] || first == '0)
            begin
                tbl_present[e.cpu] = 1'b1;
                tbl_first_seen[e.cpu] = e.now;
                tbl_ticks[e.cpu] = '0;
                tbl_last_report[e.cpu] = e.now;
                return 1'b0;
            end
            tbl_ticks[e.cpu] = tbl_ticks[e.cpu] + 1'b1;
            since = e.now - tbl_last_report[e.cpu];
            if (since > cur_threshold)
            begin
                tbl_last_report[e.cpu] = e.now;
                r.who = REPORTER_TICK;
                r.cpu = e.cpu;
                r.stamp = first;
                r.delay = e.now - first;
                r.pid = e.cur;
                return 1'b1;
            end
            return 1'b0;
        end
        // context switch
        if (!tbl_present[e.cpu])
            return 1'b0;
        first = tbl_first_seen[e.cpu];
        tbl_first_seen[e.cpu] = '0;
        since = e.now - first;
        if (cur_threshold != '0 && first != '0 && since > cur_threshold)
        begin
            tbl_last_report[e.cpu] = e.now;
            r.who = REPORTER_SWITCH;
            r.cpu = e.cpu;
            r.stamp = e.now;
            r.delay = since;
            r.enter = first;
            r.leave = e.now;
            r.pid = e.cur;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // random item: mostly plausible per-cpu timelines, some noise
    function automatic sched_event_t next_event();
        sched_event_t e;
        int span;
        bit noisy;
        noisy = ($urandom_range(0, 99) < 15);
        e.cpu = ($urandom_range(0, 3) == 0) ? CPU_W'($urandom_range(0, TB_CPUS - 1))
                                            : CPU_W'($urandom_range(0, 7));
        e.op = ($urandom_range(0, 99) < 30) ? OP_SWITCH : OP_TICK;
        span = (cur_threshold > 64'd50000) ? 100000 : int'(cur_threshold) * 2 + 20;
        e.now = cpu_clock[e.cpu] + TIME_W'($urandom_range(0, span));
        e.pid = PID_W'($urandom_range(1, PID_TOP));
        e.flags = {$urandom, $urandom} | (64'd1 << cur_flag_pos);
        e.cur = $urandom;
        if (noisy)
        begin
            e.now = ($urandom_range(0, 4) == 0) ? '0 : {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0)
                e.pid = '0;
            if ($urandom_range(0, 1) == 0)
                e.flags = e.flags & ~(64'd1 << cur_flag_pos);
        end
        cpu_clock[e.cpu] = e.now;
        return e;
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_event(input sched_event_t e);
        latency_report_t r;
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= e.op;
        cpu <= e.cpu;
        now_ns <= e.now;
        task_pid <= e.pid;
        thread_flags <= e.flags;
        current_pid <= e.cur;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (predict_report(e, r))
            expected_reports.push_back(r);
        repeat (gap_len())
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop offering, let every report drain and the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_THRESHOLD)
            cur_threshold = value;
        else
            cur_flag_pos = value[FBIT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // reset settings: zero threshold, flag bit 3
    task automatic test_reset_config_cases();
        send_event(ev(OP_SWITCH, 6'd5, 64'd50, 23'd9, 64'h8, 32'd1));
        send_event(ev(OP_TICK, 6'd5, 64'd60, 23'd0, 64'h8, 32'd2));
        send_event(ev(OP_TICK, 6'd5, 64'd70, 23'd1, 64'hFFFF_FFFF_FFFF_FFF7, 32'd3));
        send_event(ev(OP_TICK, 6'd5, 64'd100, PID_TOP, 64'h8, 32'd4));
        send_event(ev(OP_TICK, 6'd5, 64'd100, 23'd1, 64'h8, 32'd5));
        send_event(ev(OP_TICK, 6'd5, 64'd150, 23'd1, 64'h8, 32'hFFFF_FFFF));
        send_event(ev(OP_SWITCH, 6'd5, 64'd200, 23'd0, 64'h0, 32'd6));
        // armed at time zero stays armed
        send_event(ev(OP_TICK, 6'd5, 64'd0, 23'd2, 64'h8, 32'd7));
        send_event(ev(OP_TICK, 6'd5, 64'd10, 23'd2, 64'h8, 32'd8));
        // time wraps past the top
        send_event(ev(OP_TICK, 6'd63, 64'hFFFF_FFFF_FFFF_FFF0, 23'h7F_FFFF, 64'h8, 32'd9));
        send_event(ev(OP_TICK, 6'd63, 64'd5, 23'd3, 64'h8, 32'd10));
        send_event(ev(OP_TICK, 6'd0, 64'd0, 23'd4, '1, 32'd11));
        send_event(ev(OP_TICK, 6'd0, 64'd1, 23'd4, '1, 32'd12));
        wait_idle();
    endtask

    // tick and switch reports against a real threshold, then the largest one
    task automatic test_threshold_paths();
        write_reg(REG_THRESHOLD, 64'd1000);
        write_reg(REG_FLAG_BIT, 64'd0);
        send_event(ev(OP_TICK, 6'd1, 64'd1000, 23'd5, 64'h1, 32'd20));
        send_event(ev(OP_TICK, 6'd1, 64'd1500, 23'd5, 64'h1, 32'd21));
        send_event(ev(OP_TICK, 6'd1, 64'd2001, 23'd5, 64'h1, 32'd22));
        send_event(ev(OP_SWITCH, 6'd1, 64'd2001, 23'd0, 64'h0, 32'd23));
        send_event(ev(OP_TICK, 6'd1, 64'd3000, 23'd5, 64'h1, 32'd24));
        send_event(ev(OP_SWITCH, 6'd1, 64'd3500, 23'd0, 64'h0, 32'd25));
        send_event(ev(OP_SWITCH, 6'd1, 64'd9000, 23'd0, 64'h0, 32'd26));
        send_event(ev(OP_TICK, 6'd1, 64'd9500, 23'd5, 64'hFFFF_FFFF_FFFF_FFFE, 32'd27));
        wait_idle();
        write_reg(REG_THRESHOLD, TIME_TOP);
        write_reg(REG_FLAG_BIT, 64'd63);
        send_event(ev(OP_TICK, 6'd2, 64'd1, 23'd6, 64'h8000_0000_0000_0000, 32'd30));
        send_event(ev(OP_TICK, 6'd2, TIME_TOP, 23'd6, 64'h8000_0000_0000_0000, 32'd31));
        send_event(ev(OP_SWITCH, 6'd2, 64'd0, 23'd0, 64'h0, 32'd32));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input logic [CFG_W-1:0] thr,
                                       input logic [CFG_W-1:0] fbit);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FLAG_BIT, fbit);
        repeat (count) send_event(next_event());
        wait_idle();
    endtask

    // both sides run flat out
    task automatic test_streaming(input int count);
        no_gaps = 1'b1;
        write_reg(REG_THRESHOLD, 64'd0);
        write_reg(REG_FLAG_BIT, 64'd3);
        repeat (count) send_event(next_event());
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure(input int count);
        write_reg(REG_THRESHOLD, 64'd0);
        write_reg(REG_FLAG_BIT, 64'd3);
        hold_off_req = 1'b1;
        no_gaps = 1'b1;
        repeat (count) send_event(next_event());
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // receiver side ready pattern
    initial
    begin : report_sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (!no_gaps && $urandom_range(0, 99) < 30)
            begin
                stall_left = gap_len();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
        end
    endtask

    // compare each taken report with the oldest one predicted
    always @(posedge clk)
    begin : report_check
        latency_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected report, expected none actual cpu %0d delay %h",
                             $time, report_cpu, delay_ns);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("reporter", 64'(want.who), 64'(reporter));
                check_field("report_cpu", 64'(want.cpu), 64'(report_cpu));
                check_field("stamp_ns", want.stamp, stamp_ns);
                check_field("delay_ns", want.delay, delay_ns);
                check_field("enter_ns", want.enter, enter_ns);
                check_field("exit_ns", want.leave, exit_ns);
                check_field("report_pid", 64'(want.pid), 64'(report_pid));
            end
        end
    end

    // give up when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_TICK;
        cpu = '0;
        now_ns = '0;
        task_pid = '0;
        thread_flags = '0;
        current_pid = '0;
        cur_threshold = '0;
        cur_flag_pos = FLAG_BIT_RESET;
        for (int i = 0; i < TB_CPUS; i++)
        begin
            tbl_present[i] = 1'b0;
            tbl_first_seen[i] = '0;
            tbl_ticks[i] = '0;
            tbl_last_report[i] = '0;
            cpu_clock[i] = TIME_W'($urandom_range(1, 1000));
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config_cases();
        test_threshold_paths();
        test_random_traffic(200, 64'd0, 64'd3);
        test_random_traffic(200, 64'd50, 64'd0);
        test_random_traffic(200, 64'd1000, 64'd63);
        test_random_traffic(200, 64'($urandom_range(1, 1 << 17)), 64'($urandom_range(0, 63)));
        test_random_traffic(100, {$urandom | 32'h8000_0000, $urandom},
                            64'($urandom_range(0, 63)));
        test_random_traffic(200, 64'd5000, 64'($urandom_range(0, 63)));
        test_streaming(150);
        test_output_backpressure(60);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
